>>> rtl/turtle_grid_plotter_macros.svh
// Assertion macros shared by the turtle grid plotter RTL.
// Included by the top level; needs nothing else.
`ifndef TURTLE_GRID_PLOTTER_MACROS_SVH
`define TURTLE_GRID_PLOTTER_MACROS_SVH

// same-cycle implication under reset
`define TGP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define TGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tgp_pkg.sv
// Package for the turtle grid plotter: command and heading codes, result beat type.
// Used by the bitmap store, the engine and the top level; depends on nothing.
`default_nettype none

package tgp_pkg;

  localparam int GRID_DIM_DEF = 32;

  typedef enum logic [1:0] {
    CMD_LEFT  = 2'd0,
    CMD_RIGHT = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_NORTH = 2'd3
  } dir_e;

  typedef struct packed {
    logic [4:0] pos_row;
    logic [4:0] pos_col;
    dir_e       dir;
    logic       cell_value;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/tgp_bitmap_ram.sv
// Bitmap store of the turtle grid plotter: one grid row per entry, registered read.
// Per-row valid flops make unwritten rows read as cleared. Uses tgp_pkg.
`default_nettype none

module tgp_bitmap_ram
  import tgp_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF,
  localparam int AW = $clog2(GRID_DIM)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [AW-1:0]       rd_addr_i,
  output logic      [GRID_DIM-1:0] rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire logic [GRID_DIM-1:0] wr_data_i
);

  logic [GRID_DIM-1:0] mem [GRID_DIM];
  logic [GRID_DIM-1:0] row_vld_q;
  logic [GRID_DIM-1:0] rd_data_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> rtl/tgp_engine.sv
// Command engine of the turtle grid plotter: heading, position and the
// read-modify-write row sweep over the bitmap store. Uses tgp_pkg.
`default_nettype none

module tgp_engine
  import tgp_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF,
  localparam int PW = $clog2(GRID_DIM)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     busy_o,
  input  wire cmd_e                cmd_i,
  input  wire logic [7:0]          steps_i,
  input  wire logic                pen_down_i,
  input  wire logic [4:0]          read_row_i,
  input  wire logic [4:0]          read_col_i,
  output logic                     res_valid_o,
  output res_t                     res_o,
  input  wire logic                res_take_i,
  output logic                     rd_en_o,
  output logic [PW-1:0]            rd_addr_o,
  input  wire logic [GRID_DIM-1:0] rd_data_i,
  output logic                     wr_en_o,
  output logic [PW-1:0]            wr_addr_o,
  output logic [GRID_DIM-1:0]      wr_data_o
);

  localparam int XW = (PW > 5) ? PW : 5;
  localparam int SW = ((PW > 8) ? PW : 8) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]          state_q, state_d;
  dir_e                dir_q, dir_d;
  logic [PW-1:0]       row_q, row_d;
  logic [PW-1:0]       col_q, col_d;
  logic                cell_q, cell_d;
  logic [PW-1:0]       cur_q, cur_d;
  logic [PW-1:0]       hi_q, hi_d;
  logic [PW-1:0]       rc_q, rc_d;
  logic [PW-1:0]       pend_row_q;
  logic                pend_q;
  logic [GRID_DIM-1:0] mask_q, mask_d;

  logic                accept;
  logic                vert;
  logic [PW-1:0]       mv_pos;
  logic [SW-1:0]       sum;
  logic [SW-1:0]       diff;
  logic [PW-1:0]       new_pos;
  logic [PW-1:0]       new_row;
  logic [PW-1:0]       new_col;
  logic [PW-1:0]       rlo, rhi, clo, chi;
  logic [GRID_DIM-1:0] mask;
  logic [XW-1:0]       rr_ext, rc_ext, row_ext, col_ext;
  logic                rd_in_grid;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign vert   = (dir_q == DIR_SOUTH) || (dir_q == DIR_NORTH);
  assign mv_pos = vert ? row_q : col_q;
  assign sum    = SW'(mv_pos) + SW'(steps_i);
  assign diff   = SW'(mv_pos) - SW'(steps_i);

  always_comb begin
    if ((dir_q == DIR_EAST) || (dir_q == DIR_SOUTH)) begin
      new_pos = (sum >= SW'(GRID_DIM)) ? PW'(GRID_DIM - 1) : sum[PW-1:0];
    end else begin
      new_pos = (SW'(steps_i) > SW'(mv_pos)) ? '0 : diff[PW-1:0];
    end
  end

  assign new_row = vert ? new_pos : row_q;
  assign new_col = vert ? col_q : new_pos;
  assign rlo     = (row_q < new_row) ? row_q : new_row;
  assign rhi     = (row_q < new_row) ? new_row : row_q;
  assign clo     = (col_q < new_col) ? col_q : new_col;
  assign chi     = (col_q < new_col) ? new_col : col_q;

  always_comb begin
    for (int c = 0; c < GRID_DIM; c++) begin
      mask[c] = (PW'(c) >= clo) && (PW'(c) <= chi);
    end
  end

  assign rr_ext     = XW'(read_row_i);
  assign rc_ext     = XW'(read_col_i);
  assign rd_in_grid = (rr_ext <= XW'(GRID_DIM - 1)) && (rc_ext <= XW'(GRID_DIM - 1));

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    row_d   = row_q;
    col_d   = col_q;
    cell_d  = cell_q;
    cur_d   = cur_q;
    hi_d    = hi_q;
    rc_d    = rc_q;
    mask_d  = mask_q;
    rd_en_o   = 1'b0;
    rd_addr_o = cur_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cell_d  = 1'b0;
          state_d = S_DONE;
          case (cmd_i)
            CMD_LEFT: begin
              dir_d = dir_e'(dir_q + 2'd3);
            end
            CMD_RIGHT: begin
              dir_d = dir_e'(dir_q + 2'd1);
            end
            CMD_MOVE: begin
              row_d = new_row;
              col_d = new_col;
              if (pen_down_i) begin
                cur_d   = rlo;
                hi_d    = rhi;
                mask_d  = mask;
                state_d = S_SWEEP;
              end
            end
            CMD_READ: begin
              if (rd_in_grid) begin
                rd_en_o   = 1'b1;
                rd_addr_o = rr_ext[PW-1:0];
                rc_d      = rc_ext[PW-1:0];
                state_d   = S_RDWAIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SWEEP: begin
        rd_en_o = 1'b1;
        if (cur_q == hi_q) begin
          state_d = S_DRAIN;
        end else begin
          cur_d = cur_q + PW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_RDWAIT: begin
        cell_d  = rd_data_i[rc_q];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dir_q   <= DIR_EAST;
      row_q   <= '0;
      col_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pend_q  <= (state_q == S_SWEEP);
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q     <= cell_d;
    cur_q      <= cur_d;
    hi_q       <= hi_d;
    rc_q       <= rc_d;
    mask_q     <= mask_d;
    pend_row_q <= cur_q;
  end

  assign wr_en_o   = pend_q;
  assign wr_addr_o = pend_row_q;
  assign wr_data_o = rd_data_i | mask_q;

  assign row_ext = XW'(row_q);
  assign col_ext = XW'(col_q);

  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.pos_row     = row_ext[4:0];
  assign res_o.pos_col     = col_ext[4:0];
  assign res_o.dir         = dir_q;
  assign res_o.cell_value  = cell_q;

endmodule

`default_nettype wire

>>> rtl/turtle_grid_plotter.sv
// Turn or pen-up move: engine done state, then output register; a read first passes a
// read-wait state. A pen-down move first sweeps the rows covered (at most GRID_DIM) through
// the one-read one-write bitmap store, one row read-modify-write per cycle, then drains.
// One command in flight; the next beat is taken once the result leaves the engine.
// Reset (rst_ni low, async): heading east, position 0,0, bitmap reads all zero at once.
`default_nettype none

`include "turtle_grid_plotter_macros.svh"

module turtle_grid_plotter
  import tgp_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF,
  localparam int PW = $clog2(GRID_DIM)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] steps_i,
  input  wire logic       pen_down_i,
  input  wire logic [4:0] read_row_i,
  input  wire logic [4:0] read_col_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      pos_row_o,
  output logic [4:0]      pos_col_o,
  output logic [1:0]      dir_o,
  output logic            cell_value_o
);

  logic                eng_busy;
  logic                eng_res_valid;
  res_t                eng_res;
  logic                eng_take;
  logic                rd_en;
  logic [PW-1:0]       rd_addr;
  logic [GRID_DIM-1:0] rd_data;
  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  logic [GRID_DIM-1:0] wr_data;
  logic                out_valid_q;
  res_t                out_q;
  logic                in_take;
  logic                res_hold;

  tgp_engine #(
    .GRID_DIM(GRID_DIM)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (eng_busy),
    .cmd_i      (cmd_e'(cmd_i)),
    .steps_i    (steps_i),
    .pen_down_i (pen_down_i),
    .read_row_i (read_row_i),
    .read_col_i (read_col_i),
    .res_valid_o(eng_res_valid),
    .res_o      (eng_res),
    .res_take_i (eng_take),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  tgp_bitmap_ram #(
    .GRID_DIM(GRID_DIM)
  ) u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign in_stall_o = eng_busy;
  assign eng_take   = eng_res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_q <= eng_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_row_o    = out_q.pos_row;
  assign pos_col_o    = out_q.pos_col;
  assign dir_o        = out_q.dir;
  assign cell_value_o = out_q.cell_value;

  assign in_take  = in_valid_i && !in_stall_o;
  assign res_hold = eng_res_valid && !eng_take;

  `TGP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_take, in_stall_o, "idle after accept")
  `TGP_ASSERT_NOW(a_idle_no_result, clk_i, rst_ni, !in_stall_o, !eng_res_valid, "result while idle")
  `TGP_ASSERT_NEXT(a_result_held, clk_i, rst_ni, res_hold, eng_res_valid, "result dropped")
  `TGP_ASSERT_NEXT(a_result_stable, clk_i, rst_ni, res_hold, $stable(eng_res), "result changed")
  `TGP_ASSERT_NOW(a_no_write_when_idle, clk_i, rst_ni, !in_stall_o, !wr_en, "write while idle")

endmodule

`default_nettype wire
